### hdl/hcbe_pkg.sv
package hcbe_pkg;

   // line and size limits
   localparam int LINE_BUFFER = 16;
   localparam int SIZE_BITS   = 31;
   localparam int KEPT_BITS   = $clog2(LINE_BUFFER);
   localparam int BYTE_BITS   = 8;

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [KEPT_BITS-1:0] kept_type;
   typedef logic [BYTE_BITS-1:0] byte_type;

   localparam size_type SIZE_MAX   = '1;
   localparam kept_type KEPT_LIMIT = KEPT_BITS'(LINE_BUFFER - 1);

   // stream phase codes
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_DATA   = 3'd1;
   localparam logic [2:0] PH_SKIP1  = 3'd2;
   localparam logic [2:0] PH_SKIP2  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   // size parse step codes
   localparam logic [2:0] NS_BLANKS  = 3'd0;
   localparam logic [2:0] NS_SIGNED  = 3'd1;
   localparam logic [2:0] NS_ZERO    = 3'd2;
   localparam logic [2:0] NS_PREFIX  = 3'd3;
   localparam logic [2:0] NS_DIGITS  = 3'd4;
   localparam logic [2:0] NS_STOPPED = 3'd5;

   // characters
   localparam byte_type CHAR_NUL   = 8'h00;
   localparam byte_type CHAR_TAB   = 8'h09;
   localparam byte_type CHAR_LF    = 8'h0a;
   localparam byte_type CHAR_VT    = 8'h0b;
   localparam byte_type CHAR_FF    = 8'h0c;
   localparam byte_type CHAR_CR    = 8'h0d;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_PLUS  = 8'h2b;
   localparam byte_type CHAR_MINUS = 8'h2d;
   localparam byte_type CHAR_ZERO  = 8'h30;
   localparam byte_type CHAR_NINE  = 8'h39;
   localparam byte_type CHAR_UA    = 8'h41;
   localparam byte_type CHAR_UF    = 8'h46;
   localparam byte_type CHAR_UX    = 8'h58;
   localparam byte_type CHAR_LA    = 8'h61;
   localparam byte_type CHAR_LF_HEX = 8'h66;
   localparam byte_type CHAR_LX    = 8'h78;

endpackage

### hdl/hcbe_if.sv
interface hcbe_req_if;
   logic                valid;
   logic                ready;
   hcbe_pkg::byte_type  byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface hcbe_rsp_if;
   logic                valid;
   logic                ready;
   hcbe_pkg::byte_type  body_byte;
   logic                is_end;

   modport source (output valid, output body_byte, output is_end, input ready);
   modport sink (input valid, input body_byte, input is_end, output ready);
endinterface

### hdl/http_chunked_body_extractor.sv
// Chunked body extractor: takes one raw byte of an HTTP chunked body per
// transaction on req_chan and returns only the payload bytes on rsp_chan.
// Each chunk header line is parsed for a base-16 size (leading blanks, sign,
// optional 0x, hex digits, saturating at 2^31-1); CR is dropped, only the
// first 15 other bytes of a line count, blank lines are skipped, and the two
// bytes after each chunk's data are discarded. A zero, negative or missing
// size produces one transaction with is_end set and body_byte zero, after
// which every byte is swallowed until reset. The block takes one byte every
// cycle while rsp_chan does not stall it; an accepted byte sits in the input
// register, and any result it yields goes to the result register when the
// input stage advances (input register, then result register, with the
// combinational parser update between them). While a result waits on
// rsp_chan.ready the input register still takes one more byte, then
// req_chan.ready drops until the waiting result is taken.
module http_chunked_body_extractor (
   input  logic        clock,
   input  logic        reset,
   hcbe_req_if.sink    req_chan,
   hcbe_rsp_if.source  rsp_chan
);

   // input register
   logic                in_valid_ff, in_valid_in;
   hcbe_pkg::byte_type  in_byte_ff;

   // parser state
   logic [2:0]          phase_ff, phase_in;
   hcbe_pkg::kept_type  kept_ff, kept_in;
   logic [2:0]          step_ff, step_in;
   logic                neg_ff, neg_in;
   hcbe_pkg::size_type  size_ff, size_in;
   hcbe_pkg::size_type  left_ff, left_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   hcbe_pkg::byte_type  out_byte_ff;
   logic                out_end_ff;

   logic                req_accept;
   logic                advance;
   logic                produce;
   hcbe_pkg::byte_type  res_byte;
   logic                res_end;
   logic                is_blank;
   logic                is_hex;
   logic [3:0]          hex_val;
   hcbe_pkg::size_type  acc_val;
   hcbe_pkg::byte_type  c;

   // saturating size * 16 + digit
   function automatic hcbe_pkg::size_type accumulate(hcbe_pkg::size_type v, logic [3:0] d);
      logic [hcbe_pkg::SIZE_BITS+3:0] sum;
      sum = {v, 4'b0000} + {{hcbe_pkg::SIZE_BITS{1'b0}}, d};
      if (sum[hcbe_pkg::SIZE_BITS+3:hcbe_pkg::SIZE_BITS] != 4'd0) begin
         return hcbe_pkg::SIZE_MAX;
      end
      return sum[hcbe_pkg::SIZE_BITS-1:0];
   endfunction

   // handshake: the input stage moves on whenever the result slot is free or draining
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.body_byte = out_byte_ff;
   assign rsp_chan.is_end    = out_end_ff;

   assign c = in_byte_ff;

   // character classes
   always_comb begin
      is_blank = c inside {hcbe_pkg::CHAR_SPACE, hcbe_pkg::CHAR_TAB,
                           hcbe_pkg::CHAR_VT, hcbe_pkg::CHAR_FF};
      is_hex   = 1'b1;
      hex_val  = 4'd0;
      if (c inside {[hcbe_pkg::CHAR_ZERO:hcbe_pkg::CHAR_NINE]}) begin
         hex_val = 4'(c - hcbe_pkg::CHAR_ZERO);
      end else if (c inside {[hcbe_pkg::CHAR_LA:hcbe_pkg::CHAR_LF_HEX]}) begin
         hex_val = 4'(c - hcbe_pkg::CHAR_LA + 8'd10);
      end else if (c inside {[hcbe_pkg::CHAR_UA:hcbe_pkg::CHAR_UF]}) begin
         hex_val = 4'(c - hcbe_pkg::CHAR_UA + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign acc_val = accumulate(size_ff, hex_val);

   // per-byte state update
   always_comb begin
      phase_in = phase_ff;
      kept_in  = kept_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      size_in  = size_ff;
      left_in  = left_ff;
      produce  = 1'b0;
      res_byte = '0;
      res_end  = 1'b0;
      case (phase_ff)
         hcbe_pkg::PH_HEADER: begin
            if (c == hcbe_pkg::CHAR_LF) begin
               // end of header line: clear the line parse in every case
               kept_in = '0;
               step_in = hcbe_pkg::NS_BLANKS;
               neg_in  = 1'b0;
               size_in = '0;
               if (kept_ff != '0) begin
                  if (neg_ff || size_ff == '0) begin
                     phase_in = hcbe_pkg::PH_DONE;
                     produce  = 1'b1;
                     res_end  = 1'b1;
                  end else begin
                     left_in  = size_ff;
                     phase_in = hcbe_pkg::PH_DATA;
                  end
               end
            end else if (c != hcbe_pkg::CHAR_CR && kept_ff < hcbe_pkg::KEPT_LIMIT) begin
               kept_in = kept_ff + 1'b1;
               if (c == hcbe_pkg::CHAR_NUL) begin
                  step_in = hcbe_pkg::NS_STOPPED;
               end else begin
                  case (step_ff)
                     hcbe_pkg::NS_BLANKS, hcbe_pkg::NS_SIGNED: begin
                        if (step_ff == hcbe_pkg::NS_BLANKS && is_blank) begin
                           step_in = step_ff;
                        end else if (step_ff == hcbe_pkg::NS_BLANKS &&
                                     (c == hcbe_pkg::CHAR_PLUS || c == hcbe_pkg::CHAR_MINUS)) begin
                           neg_in  = (c == hcbe_pkg::CHAR_MINUS);
                           step_in = hcbe_pkg::NS_SIGNED;
                        end else if (c == hcbe_pkg::CHAR_ZERO) begin
                           step_in = hcbe_pkg::NS_ZERO;
                        end else if (is_hex) begin
                           size_in = acc_val;
                           step_in = hcbe_pkg::NS_DIGITS;
                        end else begin
                           step_in = hcbe_pkg::NS_STOPPED;
                        end
                     end
                     hcbe_pkg::NS_ZERO, hcbe_pkg::NS_PREFIX, hcbe_pkg::NS_DIGITS: begin
                        if (step_ff == hcbe_pkg::NS_ZERO &&
                            (c == hcbe_pkg::CHAR_LX || c == hcbe_pkg::CHAR_UX)) begin
                           step_in = hcbe_pkg::NS_PREFIX;
                        end else if (is_hex) begin
                           size_in = acc_val;
                           step_in = hcbe_pkg::NS_DIGITS;
                        end else begin
                           step_in = hcbe_pkg::NS_STOPPED;
                        end
                     end
                     default: begin
                        step_in = step_ff;
                     end
                  endcase
               end
            end
         end
         hcbe_pkg::PH_DATA: begin
            produce  = 1'b1;
            res_byte = c;
            if (left_ff != '0) begin
               left_in = left_ff - 1'b1;
            end
            if (left_in == '0) begin
               phase_in = hcbe_pkg::PH_SKIP1;
            end
         end
         hcbe_pkg::PH_SKIP1: begin
            phase_in = hcbe_pkg::PH_SKIP2;
         end
         hcbe_pkg::PH_SKIP2: begin
            phase_in = hcbe_pkg::PH_HEADER;
            kept_in  = '0;
            step_in  = hcbe_pkg::NS_BLANKS;
            neg_in   = 1'b0;
            size_in  = '0;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = (out_valid_ff && !rsp_chan.ready) || (advance && produce);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= hcbe_pkg::PH_HEADER;
         kept_ff      <= '0;
         step_ff      <= hcbe_pkg::NS_BLANKS;
         neg_ff       <= 1'b0;
         size_ff      <= '0;
         left_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            kept_ff  <= kept_in;
            step_ff  <= step_in;
            neg_ff   <= neg_in;
            size_ff  <= size_in;
            left_ff  <= left_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_chan.byte_in;
      end
      if (advance && produce) begin
         out_byte_ff <= res_byte;
         out_end_ff  <= res_end;
      end
   end

   // end marker never carries a payload byte
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_end_ff |-> out_byte_ff == '0)
      else $error("end marker with nonzero byte");

   // once ended, the stream stays ended
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hcbe_pkg::PH_DONE |=> phase_ff == hcbe_pkg::PH_DONE)
      else $error("left done phase");

   // data phase always has bytes left to pass
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hcbe_pkg::PH_DATA |-> left_ff != '0)
      else $error("data phase with empty count");

   // kept count never passes the line limit
   a_kept_limit: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= hcbe_pkg::KEPT_LIMIT)
      else $error("kept count past line limit");

   // a held result is not overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !(advance && produce))
      else $error("result overwritten while stalled");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   // one raw stream byte waiting to go out, with a flag that holds it back
   // until every body result already owed has come out
   typedef struct {
      hcbe_pkg::byte_type value;
      bit                 drain;
   } stream_byte_type;

   // one body result as the decoder should return it
   typedef struct {
      hcbe_pkg::byte_type body_byte;
      logic               is_end;
   } body_result_type;

   localparam longint unsigned SIZE_CAP = (64'd1 << hcbe_pkg::SIZE_BITS) - 64'd1;
   localparam int HOLD_AT     = 300;   // stream bytes taken before the long hold
   localparam int HOLD_CYCLES = 150;   // length of the long receiver hold

   logic clock = 1'b0;
   logic reset = 1'b1;

   hcbe_req_if req_chan ();
   hcbe_rsp_if rsp_chan ();

   http_chunked_body_extractor u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   stream_byte_type pending_bytes[$];
   body_result_type expected_body[$];

   bit    drain_next;
   bit    req_fire;
   int    send_gap;
   int    take_gap;
   int    rsp_hold_left;
   bit    hold_used;
   int    bytes_accepted;
   int    results_checked;
   int    end_markers;
   int    error_count;
   int    tail_bytes;
   string end_kind_name;

   // ------------------------------------------------------------------
   // chunk decoder prediction: own copy of the header parser state
   // ------------------------------------------------------------------
   logic [2:0]      stream_phase = hcbe_pkg::PH_HEADER;
   int              line_kept    = 0;
   logic [2:0]      parse_step   = hcbe_pkg::NS_BLANKS;
   bit              size_neg     = 1'b0;
   longint unsigned size_acc     = 0;
   longint unsigned chunk_left   = 0;

   function automatic int hex_value(hcbe_pkg::byte_type c);
      if (c >= hcbe_pkg::CHAR_ZERO && c <= hcbe_pkg::CHAR_NINE)
         return int'(c) - int'(hcbe_pkg::CHAR_ZERO);
      if (c >= hcbe_pkg::CHAR_LA && c <= hcbe_pkg::CHAR_LF_HEX)
         return int'(c) - int'(hcbe_pkg::CHAR_LA) + 10;
      if (c >= hcbe_pkg::CHAR_UA && c <= hcbe_pkg::CHAR_UF)
         return int'(c) - int'(hcbe_pkg::CHAR_UA) + 10;
      return -1;
   endfunction

   // saturating base-16 accumulate
   function automatic void add_size_digit(int d);
      if (size_acc > (SIZE_CAP - d) / 16) size_acc = SIZE_CAP;
      else size_acc = size_acc * 16 + d;
   endfunction

   function automatic void restart_line();
      line_kept  = 0;
      parse_step = hcbe_pkg::NS_BLANKS;
      size_neg   = 1'b0;
      size_acc   = 0;
   endfunction

   // strtol-style walk: blanks, sign, leading zero, x prefix, digits
   function automatic void parse_size_char(hcbe_pkg::byte_type c);
      int         d;
      logic [2:0] s;
      d = hex_value(c);
      s = parse_step;
      if (s == hcbe_pkg::NS_BLANKS) begin
         if (c == hcbe_pkg::CHAR_SPACE || c == hcbe_pkg::CHAR_TAB ||
             c == hcbe_pkg::CHAR_VT || c == hcbe_pkg::CHAR_FF) return;
         if (c == hcbe_pkg::CHAR_PLUS || c == hcbe_pkg::CHAR_MINUS) begin
            size_neg   = (c == hcbe_pkg::CHAR_MINUS);
            parse_step = hcbe_pkg::NS_SIGNED;
            return;
         end
         s = hcbe_pkg::NS_SIGNED;
      end
      if (s == hcbe_pkg::NS_SIGNED) begin
         if (c == hcbe_pkg::CHAR_ZERO) begin
            parse_step = hcbe_pkg::NS_ZERO;
         end else if (d >= 0) begin
            add_size_digit(d);
            parse_step = hcbe_pkg::NS_DIGITS;
         end else begin
            parse_step = hcbe_pkg::NS_STOPPED;
         end
         return;
      end
      if (s == hcbe_pkg::NS_ZERO) begin
         if (c == hcbe_pkg::CHAR_LX || c == hcbe_pkg::CHAR_UX) begin
            parse_step = hcbe_pkg::NS_PREFIX;
            return;
         end
         s = hcbe_pkg::NS_DIGITS;
      end
      if (s == hcbe_pkg::NS_PREFIX || s == hcbe_pkg::NS_DIGITS) begin
         if (d >= 0) begin
            add_size_digit(d);
            parse_step = hcbe_pkg::NS_DIGITS;
         end else begin
            parse_step = hcbe_pkg::NS_STOPPED;
         end
      end
   endfunction

   // advance the prediction by one taken byte, queue any result it causes
   function automatic void decode_stream_byte(hcbe_pkg::byte_type c);
      body_result_type r;
      case (stream_phase)
         hcbe_pkg::PH_HEADER: begin
            if (c == hcbe_pkg::CHAR_LF) begin
               if (line_kept != 0) begin
                  if (size_neg || size_acc == 0) begin
                     // zero, negative or missing size closes the body
                     stream_phase = hcbe_pkg::PH_DONE;
                     r.body_byte  = '0;
                     r.is_end     = 1'b1;
                     expected_body.push_back(r);
                  end else begin
                     chunk_left   = size_acc & SIZE_CAP;
                     stream_phase = hcbe_pkg::PH_DATA;
                  end
               end
               restart_line();
            end else if (c != hcbe_pkg::CHAR_CR && line_kept < hcbe_pkg::LINE_BUFFER - 1) begin
               line_kept++;
               if (c == hcbe_pkg::CHAR_NUL) parse_step = hcbe_pkg::NS_STOPPED;
               else parse_size_char(c);
            end
         end
         hcbe_pkg::PH_DATA: begin
            r.body_byte = c;
            r.is_end    = 1'b0;
            expected_body.push_back(r);
            if (chunk_left > 0) chunk_left--;
            if (chunk_left == 0) stream_phase = hcbe_pkg::PH_SKIP1;
         end
         hcbe_pkg::PH_SKIP1: stream_phase = hcbe_pkg::PH_SKIP2;
         hcbe_pkg::PH_SKIP2: begin
            stream_phase = hcbe_pkg::PH_HEADER;
            restart_line();
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stream building helpers
   // ------------------------------------------------------------------
   task automatic add_byte(hcbe_pkg::byte_type b);
      stream_byte_type item;
      item.value = b;
      item.drain = drain_next;
      pending_bytes.push_back(item);
      drain_next = 1'b0;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(hcbe_pkg::byte_type'(s[i]));
   endtask

   task automatic add_crlf();
      add_byte(hcbe_pkg::CHAR_CR);
      add_byte(hcbe_pkg::CHAR_LF);
   endtask

   function automatic hcbe_pkg::byte_type any_but_lf();
      hcbe_pkg::byte_type r;
      r = hcbe_pkg::byte_type'($urandom_range(0, 255));
      return (r == hcbe_pkg::CHAR_LF) ? hcbe_pkg::CHAR_SPACE : r;
   endfunction

   task automatic add_payload(int count);
      repeat (count) add_byte(hcbe_pkg::byte_type'($urandom_range(0, 255)));
   endtask

   // the two bytes after the data are dropped unchecked, so sometimes junk
   task automatic add_trailer();
      if ($urandom_range(0, 4) != 0) begin
         add_crlf();
      end else begin
         add_byte(hcbe_pkg::byte_type'($urandom_range(0, 255)));
         add_byte(hcbe_pkg::byte_type'($urandom_range(0, 255)));
      end
   endtask

   // well-formed header for a positive size, random spelling
   task automatic add_chunk_header(int size);
      string              digits;
      hcbe_pkg::byte_type ch;
      int                 blanks;
      blanks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (blanks) begin
         case ($urandom_range(0, 3))
            0: add_byte(hcbe_pkg::CHAR_SPACE);
            1: add_byte(hcbe_pkg::CHAR_TAB);
            2: add_byte(hcbe_pkg::CHAR_VT);
            default: add_byte(hcbe_pkg::CHAR_FF);
         endcase
      end
      if ($urandom_range(0, 4) == 0) add_byte(hcbe_pkg::CHAR_PLUS);
      case ($urandom_range(0, 5))
         0: add_text("0x");
         1: add_text("0X");
         2: repeat ($urandom_range(1, 2)) add_byte(hcbe_pkg::CHAR_ZERO);
         default: ;
      endcase
      digits = $sformatf("%0h", size);
      for (int i = 0; i < digits.len(); i++) begin
         ch = hcbe_pkg::byte_type'(digits[i]);
         if (ch >= hcbe_pkg::CHAR_LA && $urandom_range(0, 1) == 1) ch = ch - 8'h20;
         // a cr in the middle of the digits is dropped
         if ($urandom_range(0, 9) == 0) add_byte(hcbe_pkg::CHAR_CR);
         add_byte(ch);
      end
      case ($urandom_range(0, 5))
         0: add_text(";name=v");
         1: begin
            // long extension that can run past the kept part of the line
            add_byte(hcbe_pkg::CHAR_SPACE);
            repeat ($urandom_range(12, 24)) add_byte(any_but_lf());
         end
         default: ;
      endcase
      if ($urandom_range(0, 3) != 0) add_byte(hcbe_pkg::CHAR_CR);
      add_byte(hcbe_pkg::CHAR_LF);
   endtask

   // idle lengths: mostly none or short, a few long, none in calm windows
   function automatic int pick_gap();
      int r;
      if (((bytes_accepted >> 6) % 3) == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic report_mismatch(string field, int want, int got);
      error_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
   endtask

   // ------------------------------------------------------------------
   // sender: stream bytes change on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         if (send_gap > 0 && rsp_hold_left == 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_bytes.size() == 0 ||
                      (pending_bytes[0].drain && expected_body.size() != 0)) begin
            // nothing left, or pausing until the owed results are all out
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.byte_in <= pending_bytes[0].value;
            req_chan.valid   <= 1'b1;
            void'(pending_bytes.pop_front());
            // keep offering while the receiver is held off
            send_gap = (rsp_hold_left > 0) ? 0 : pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: ready changes on the falling edge, one long hold-off once
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!hold_used && bytes_accepted >= HOLD_AT) begin
            hold_used     = 1'b1;
            rsp_hold_left = HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            take_gap = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: both handshakes sampled on the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      body_result_type want;
      req_fire = !reset && req_chan.valid && req_chan.ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_body.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none actual %s %0h is_end %0b",
                     $time, "body_byte", rsp_chan.body_byte, rsp_chan.is_end);
         end else begin
            want = expected_body.pop_front();
            if (rsp_chan.body_byte !== want.body_byte)
               report_mismatch("body_byte", want.body_byte, rsp_chan.body_byte);
            if (rsp_chan.is_end !== want.is_end)
               report_mismatch("is_end", want.is_end, rsp_chan.is_end);
            results_checked++;
            if (want.is_end) end_markers++;
         end
      end
      if (req_fire) begin
         decode_stream_byte(req_chan.byte_in);
         bytes_accepted++;
      end
   end

   // run limit
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int  directed_count;
      int  chunk_size;
      int  r;
      int  guard;
      bit  mid_pause_set;

      req_chan.valid   = 1'b0;
      req_chan.byte_in = '0;
      rsp_chan.ready   = 1'b0;

      // blank lines, bare lf and cr lf, are skipped
      add_byte(hcbe_pkg::CHAR_LF);
      add_crlf();
      // every blank kind, plus sign and upper-case prefix
      add_byte(hcbe_pkg::CHAR_SPACE);
      add_byte(hcbe_pkg::CHAR_TAB);
      add_byte(hcbe_pkg::CHAR_VT);
      add_byte(hcbe_pkg::CHAR_FF);
      add_byte(hcbe_pkg::CHAR_PLUS);
      add_text("0X1");
      add_crlf();
      add_byte(8'hff);
      add_text("zz");                  // trailer bytes taken whatever they are
      // a nul after the digits ends the parse, line still counts
      add_text("5");
      add_byte(hcbe_pkg::CHAR_NUL);
      add_text("7");
      add_byte(hcbe_pkg::CHAR_LF);
      add_byte(8'h00);
      add_byte(hcbe_pkg::CHAR_LF);
      add_byte(hcbe_pkg::CHAR_CR);
      add_byte(8'h80);
      add_byte(8'h7f);
      add_crlf();
      // long line: the 16th byte is not kept, size stays one
      add_text("000000000000001F");
      add_byte(hcbe_pkg::CHAR_LF);
      add_byte(8'h55);
      add_crlf();
      // lower-case prefix with a leading zero digit and a cr inside
      add_text("0x0");
      add_byte(hcbe_pkg::CHAR_CR);
      add_text("2;");
      add_byte(hcbe_pkg::CHAR_LF);
      add_byte(8'haa);
      add_byte(8'h0f);
      add_crlf();
      directed_count = pending_bytes.size();

      // random well-formed chunks; pause the sender before the first one
      // and once more midway
      drain_next    = 1'b1;
      mid_pause_set = 1'b0;
      while (pending_bytes.size() - directed_count < 500) begin
         if (!mid_pause_set && pending_bytes.size() > 320) begin
            drain_next    = 1'b1;
            mid_pause_set = 1'b1;
         end
         if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1) == 1) add_byte(hcbe_pkg::CHAR_CR);
            add_byte(hcbe_pkg::CHAR_LF);
         end
         r = $urandom_range(0, 99);
         if (r < 75) chunk_size = $urandom_range(1, 8);
         else if (r < 95) chunk_size = $urandom_range(9, 40);
         else chunk_size = $urandom_range(64, 200);
         add_chunk_header(chunk_size);
         add_payload(chunk_size);
         add_trailer();
      end

      // the body can close only once per run, so pick one way to close it
      case ($urandom_range(0, 6))
         0: begin
            end_kind_name = "a zero size";
            add_text("0");
         end
         1: begin
            end_kind_name = "a saturated negative size";
            add_text("-FFFFFFFFFFFF");
         end
         2: begin
            end_kind_name = "a prefix with no digits";
            add_text("0xg");
         end
         3: begin
            end_kind_name = "a line with no digits";
            add_text("zz");
         end
         4: begin
            end_kind_name = "a leading nul";
            add_byte(hcbe_pkg::CHAR_NUL);
            add_text("5");
         end
         5: begin
            end_kind_name = "a negative size";
            add_text("-5");
         end
         default: begin
            end_kind_name = "blanks and a signed zero";
            add_byte(hcbe_pkg::CHAR_SPACE);
            add_byte(hcbe_pkg::CHAR_TAB);
            add_text("+0");
         end
      endcase
      add_crlf();

      // everything after the end marker is swallowed
      tail_bytes = pending_bytes.size();
      add_chunk_header(3);
      add_payload(3);
      add_trailer();
      repeat (16) add_byte(hcbe_pkg::byte_type'($urandom_range(0, 255)));
      tail_bytes = pending_bytes.size() - tail_bytes;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for the last byte to be taken, then for the owed results
      while (pending_bytes.size() != 0 || req_chan.valid) @(posedge clock);
      guard = 0;
      while (expected_body.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      // keep running to catch any stray transaction
      repeat (10) @(posedge clock);

      if (expected_body.size() != 0) begin
         error_count++;
         $display("%0t: %0d body results never came out, expected body_byte %0h is_end %0b",
                  $time, expected_body.size(), expected_body[0].body_byte,
                  expected_body[0].is_end);
      end

      $display("covered %0d stream bytes (%0d after the end), %0d body results checked",
               bytes_accepted, tail_bytes, results_checked);
      $display("body closed by %s, %0d end marker seen, receiver held off %0d cycles once",
               end_kind_name, end_markers, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/hcbe_pkg.sv
hdl/hcbe_if.sv
hdl/http_chunked_body_extractor.sv
tb/sv/tb_top.sv
